// ===== hdl/lgs_pkg.sv =====
// Shared types, constants and codes for the life grid generation step block.
package lgs_pkg;

	localparam int GRID_ROWS = 16;
	localparam int GRID_COLS = 16;
	localparam int ROW_AW    = $clog2(GRID_ROWS);
	localparam int COL_AW    = $clog2(GRID_COLS);

	// Neighbor counts that keep a live cell, and the one that gives birth.
	localparam int KEEP_LO = 2;
	localparam int BIRTH   = 3;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef logic [GRID_COLS-1:0] grid_row_t;

	typedef struct packed {
		cmd_t       command;
		logic [3:0] row;
		logic [3:0] col;
		logic       cell_value;
	} req_t;

	typedef struct packed {
		logic [3:0]  row_index;
		logic [15:0] row_bits;
		logic        last_row;
	} rpt_t;

	typedef struct packed {
		logic              en;
		logic [ROW_AW-1:0] addr;
		grid_row_t         data;
	} grid_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_GEN
	} state_t;

endpackage

// ===== hdl/lgs_grid.sv =====
// Cell grid storage: one row written and one row read per cycle.
module lgs_grid (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lgs_pkg::grid_wr_t                wr,
	input  logic [lgs_pkg::ROW_AW-1:0]       rd_addr,
	output lgs_pkg::grid_row_t               rd_data
);

	lgs_pkg::grid_row_t rows_q [lgs_pkg::GRID_ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lgs_pkg::GRID_ROWS; i++) begin
				rows_q[i] <= '0;
			end
		end else if (wr.en) begin
			rows_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = rows_q[rd_addr];

endmodule

// ===== hdl/lgs_row_rule.sv =====
// Next-generation row from three old rows; cells past the border count dead.
module lgs_row_rule (
	input  lgs_pkg::grid_row_t above,
	input  lgs_pkg::grid_row_t cur,
	input  lgs_pkg::grid_row_t below,
	output lgs_pkg::grid_row_t next_row
);

	logic [lgs_pkg::GRID_COLS+1:0] a_x;
	logic [lgs_pkg::GRID_COLS+1:0] c_x;
	logic [lgs_pkg::GRID_COLS+1:0] b_x;

	// pad one dead column on each side
	assign a_x = {1'b0, above, 1'b0};
	assign c_x = {1'b0, cur, 1'b0};
	assign b_x = {1'b0, below, 1'b0};

	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < lgs_pkg::GRID_COLS; c++) begin
			n = 4'(a_x[c]) + 4'(a_x[c+1]) + 4'(a_x[c+2])
			  + 4'(c_x[c]) + 4'(c_x[c+2])
			  + 4'(b_x[c]) + 4'(b_x[c+1]) + 4'(b_x[c+2]);
			if (cur[c]) begin
				next_row[c] = (n == 4'(lgs_pkg::KEEP_LO)) || (n == 4'(lgs_pkg::BIRTH));
			end else begin
				next_row[c] = (n == 4'(lgs_pkg::BIRTH));
			end
		end
	end

endmodule

// ===== hdl/life_grid_generation_step_core.sv =====
// Top level: Life grid with cell write, row read and one-generation step.
//
//  channel | valid      | stall      | word | carries
//  --------+------------+------------+------+------------------------------------
//  request | req_valid  | req_stall  | req  | command, row, col, cell_value
//  report  | rpt_valid  | rpt_stall  | rpt  | row_index, row_bits, last_row
//
// A write or read command yields one report word.
// A step command runs in steps: the accept starts the sequencer, the prime state
// loads the first old row into the window, then one row per cycle, while the report
// is not stalled, passes through the single row-rule unit and is written back and
// reported.
// Reset clears the grid, the sequencer and the report valid flag at once; the report word has no reset.
// A stalled report holds; the sequencer waits on it and accepts no request
// until the last row of a step has been loaded into the report register.
module life_grid_generation_step_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  lgs_pkg::req_t   req,
	output logic            rpt_valid,
	input  logic            rpt_stall,
	output lgs_pkg::rpt_t   rpt
);

	lgs_pkg::state_t state_q;
	lgs_pkg::state_t state_nxt;

	logic [lgs_pkg::ROW_AW-1:0] row_q;
	lgs_pkg::grid_row_t         above_q;
	lgs_pkg::grid_row_t         cur_q;
	logic                       out_valid_q;
	lgs_pkg::rpt_t              out_q;

	logic                       out_free;
	logic                       take;
	logic                       row_in_range;
	logic                       col_in_range;
	logic                       last_gen;
	logic [lgs_pkg::ROW_AW-1:0] rd_addr;
	lgs_pkg::grid_row_t         rd_data;
	lgs_pkg::grid_row_t         below;
	lgs_pkg::grid_row_t         next_row;
	lgs_pkg::grid_row_t         cell_mask;
	lgs_pkg::grid_row_t         written;
	lgs_pkg::grid_wr_t          wr;
	logic                       load_out;
	lgs_pkg::rpt_t              out_nxt;
	logic                       prime;
	logic                       advance;

	// The report register is free when empty or being taken this cycle.
	assign out_free  = !out_valid_q || !rpt_stall;
	assign req_stall = !((state_q == lgs_pkg::ST_IDLE) && out_free);
	assign take      = req_valid && !req_stall;

	assign row_in_range = 32'(req.row) < lgs_pkg::GRID_ROWS;
	assign col_in_range = 32'(req.col) < lgs_pkg::GRID_COLS;
	assign last_gen     = (row_q == lgs_pkg::ROW_AW'(lgs_pkg::GRID_ROWS - 1));

	// Read port: requested row when idle, row zero to prime, next old row while stepping.
	always_comb begin
		unique case (state_q)
			lgs_pkg::ST_IDLE:  rd_addr = lgs_pkg::ROW_AW'(req.row);
			lgs_pkg::ST_PRIME: rd_addr = '0;
			lgs_pkg::ST_GEN:   rd_addr = row_q + lgs_pkg::ROW_AW'(1);
			default:           rd_addr = '0;
		endcase
	end

	lgs_grid u_grid (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Below the bottom row everything is dead.
	assign below = last_gen ? '0 : rd_data;

	lgs_row_rule u_rule (
		.above    (above_q),
		.cur      (cur_q),
		.below    (below),
		.next_row (next_row)
	);

	// Single-cell update of the addressed row; out-of-range column leaves it as is.
	assign cell_mask = col_in_range ?
		(lgs_pkg::grid_row_t'(1) << lgs_pkg::COL_AW'(req.col)) : '0;
	assign written   = req.cell_value ? (rd_data | cell_mask) : (rd_data & ~cell_mask);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lgs_pkg::ST_IDLE: begin
				if (take && (req.command == lgs_pkg::CMD_STEP)) begin
					state_nxt = lgs_pkg::ST_PRIME;
				end
			end
			lgs_pkg::ST_PRIME: state_nxt = lgs_pkg::ST_GEN;
			lgs_pkg::ST_GEN: begin
				if (out_free && last_gen) begin
					state_nxt = lgs_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lgs_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: grid write, report load, window moves.
	always_comb begin
		wr       = '0;
		load_out = 1'b0;
		out_nxt  = '0;
		prime    = 1'b0;
		advance  = 1'b0;
		unique case (state_q)
			lgs_pkg::ST_IDLE: begin
				if (take) begin
					unique case (req.command)
						lgs_pkg::CMD_WRITE: begin
							wr.en             = row_in_range;
							wr.addr           = rd_addr;
							wr.data           = written;
							load_out          = 1'b1;
							out_nxt.row_index = req.row;
							out_nxt.row_bits  = row_in_range ? 16'(written) : '0;
							out_nxt.last_row  = 1'b1;
						end
						lgs_pkg::CMD_READ: begin
							load_out          = 1'b1;
							out_nxt.row_index = req.row;
							out_nxt.row_bits  = row_in_range ? 16'(rd_data) : '0;
							out_nxt.last_row  = 1'b1;
						end
						lgs_pkg::CMD_STEP, lgs_pkg::CMD_NONE: begin
							load_out = 1'b0;
						end
						default: load_out = 1'b0;
					endcase
				end
			end
			lgs_pkg::ST_PRIME: begin
				prime = 1'b1;
			end
			lgs_pkg::ST_GEN: begin
				// hold the window while the report word is stalled
				if (out_free) begin
					wr.en             = 1'b1;
					wr.addr           = row_q;
					wr.data           = next_row;
					load_out          = 1'b1;
					out_nxt.row_index = 4'(row_q);
					out_nxt.row_bits  = 16'(next_row);
					out_nxt.last_row  = last_gen;
					advance           = 1'b1;
				end
			end
			default: load_out = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lgs_pkg::ST_IDLE;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (prime) begin
				row_q <= '0;
			end else if (advance) begin
				row_q <= row_q + lgs_pkg::ROW_AW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rpt_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Old-row window and report word: payload, no reset.
	always_ff @(posedge clk) begin
		if (prime) begin
			above_q <= '0;
			cur_q   <= rd_data;
		end else if (advance) begin
			above_q <= cur_q;
			cur_q   <= below;
		end
		if (load_out) begin
			out_q <= out_nxt;
		end
	end

	assign rpt_valid = out_valid_q;
	assign rpt       = out_q;

endmodule

// ===== tb/life_grid_mirror.sv =====
// Checker for the Life grid block: mirrors the grid, predicts report words and compares them.
module life_grid_mirror (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  lgs_pkg::req_t   req,
	input  logic            rpt_valid,
	input  logic            rpt_stall,
	input  lgs_pkg::rpt_t   rpt,
	output int              mismatch_count,
	output int              rows_due
);
	import lgs_pkg::*;

	grid_row_t life_grid [GRID_ROWS] = '{default: '0};
	grid_row_t next_grid [GRID_ROWS] = '{default: '0};
	rpt_t      due_rows [$];

	initial begin
		mismatch_count = 0;
		rows_due       = 0;
	end

	// Cells beyond the border count as dead.
	function automatic logic cell_alive(input int r, input int c);
		if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS)
			return 1'b0;
		return life_grid[r][c];
	endfunction

	function automatic grid_row_t evolve_row(input int r);
		grid_row_t bits;
		int        n;
		bits = '0;
		for (int c = 0; c < GRID_COLS; c++) begin
			n = 0;
			for (int dr = -1; dr <= 1; dr++)
				for (int dc = -1; dc <= 1; dc++)
					if (dr != 0 || dc != 0)
						n += int'(cell_alive(r + dr, c + dc));
			if (life_grid[r][c])
				bits[c] = (n == KEEP_LO || n == BIRTH);
			else
				bits[c] = (n == BIRTH);
		end
		return bits;
	endfunction

	function automatic void queue_row(input int idx, input grid_row_t bits, input logic last);
		rpt_t w;
		w.row_index = idx[3:0];
		w.row_bits  = bits;
		w.last_row  = last;
		due_rows.push_back(w);
	endfunction

	// The 4-bit indexes cover the whole 16x16 grid, so every write lands.
	function automatic void apply_command(input req_t w);
		case (w.command)
			CMD_WRITE: begin
				life_grid[w.row][w.col] = w.cell_value;
				queue_row(int'(w.row), life_grid[w.row], 1'b1);
			end
			CMD_READ:
				queue_row(int'(w.row), life_grid[w.row], 1'b1);
			CMD_STEP: begin
				// Count neighbors on the old grid only, then commit.
				for (int r = 0; r < GRID_ROWS; r++)
					next_grid[r] = evolve_row(r);
				for (int r = 0; r < GRID_ROWS; r++) begin
					life_grid[r] = next_grid[r];
					queue_row(r, life_grid[r], r == GRID_ROWS - 1);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void check_word(input rpt_t got);
		rpt_t want;
		if (due_rows.size() == 0) begin
			$error("report word with none due: row_index %0d row_bits %h last_row %b",
				got.row_index, got.row_bits, got.last_row);
			mismatch_count++;
			return;
		end
		want = due_rows.pop_front();
		if (got.row_index !== want.row_index) begin
			$error("row_index: expected %0d, actual %0d", want.row_index, got.row_index);
			mismatch_count++;
		end
		if (got.row_bits !== want.row_bits) begin
			$error("row_bits: expected %h, actual %h", want.row_bits, got.row_bits);
			mismatch_count++;
		end
		if (got.last_row !== want.last_row) begin
			$error("last_row: expected %b, actual %b", want.last_row, got.last_row);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (life_grid[r])
				life_grid[r] = '0;
			due_rows.delete();
		end else begin
			if (req_valid && !req_stall)
				apply_command(req);
			if (rpt_valid && !rpt_stall)
				check_word(rpt);
		end
		rows_due = due_rows.size();
	end

endmodule

// ===== tb/tb_life_grid_generation_step_core.sv =====
// Testbench top for the Life grid block: drives request words, idles both sides, gives the verdict.
module tb_life_grid_generation_step_core;
	import lgs_pkg::*;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic rpt_stall = 1'b0;
	logic req_stall;
	logic rpt_valid;
	rpt_t rpt;

	// Idle chances in percent: sender gaps and receiver stalls.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int mismatch_count;
	int rows_due;

	life_grid_generation_step_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.rpt       (rpt)
	);

	life_grid_mirror mirror (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rpt_valid      (rpt_valid),
		.rpt_stall      (rpt_stall),
		.rpt            (rpt),
		.mismatch_count (mismatch_count),
		.rows_due       (rows_due)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver side: stall at random on every falling edge, whether or not a word waits.
	always @(negedge clk) begin
		rpt_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Present one request word. Enter and leave at a falling edge.
	// Hold valid high across back-to-back words; drop it only for a gap.
	task automatic send_word(input req_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		// Hold the word until an edge sees it without stall.
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_cmd(input cmd_t c, input int r, input int col, input logic v);
		req_t w;
		w.command    = c;
		w.row        = r[3:0];
		w.col        = col[3:0];
		w.cell_value = v;
		send_word(w);
	endtask

	// Drop valid and hold off until every due report word has come back.
	// Always wait on a falling edge before checking, so valid never falls and rises in one step.
	task automatic wait_empty();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (rows_due != 0);
	endtask

	// Random traffic: writes cluster in a window so live patterns form and
	// evolve, with steps often enough to run several generations on them.
	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		int   n;
		int   pick;
		int   win_r;
		int   win_c;
		req_t w;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		win_r = $urandom_range(0, 15);
		win_c = $urandom_range(0, 15);
		n = 0;
		while (n < count) begin
			pick         = $urandom_range(0, 99);
			w.row        = 4'($urandom_range(0, 15));
			w.col        = 4'($urandom_range(0, 15));
			w.cell_value = 1'($urandom_range(0, 1));
			if (pick < 4) begin
				w.command = CMD_NONE;
			end else if (pick < 20) begin
				w.command = CMD_STEP;
				// Move the write window now and then, borders included.
				if ($urandom_range(0, 9) < 3) begin
					win_r = $urandom_range(0, 15);
					win_c = $urandom_range(0, 15);
				end
			end else if (pick < 35) begin
				w.command = CMD_READ;
			end else begin
				w.command = CMD_WRITE;
				if ($urandom_range(0, 3) != 0) begin
					w.row = 4'(win_r + $urandom_range(0, 4));
					w.col = 4'(win_c + $urandom_range(0, 4));
				end
				w.cell_value = ($urandom_range(0, 9) < 6);
			end
			send_word(w);
			// Unused command words are dropped by the block; do not count them.
			if (w.command != CMD_NONE)
				n++;
		end
	endtask

	initial begin
		// Hold reset low, then release it on a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct  = 19;
		recv_stall_pct = 51;

		// Directed: empty read, corner block, far-corner birth, blinker, lone cell.
		send_cmd(CMD_READ, 0, 0, 1'b0);
		send_cmd(CMD_WRITE, 0, 0, 1'b1);
		send_cmd(CMD_WRITE, 0, 1, 1'b1);
		send_cmd(CMD_WRITE, 1, 0, 1'b1);
		send_cmd(CMD_WRITE, 1, 1, 1'b1);
		send_cmd(CMD_WRITE, 15, 15, 1'b1);
		send_cmd(CMD_WRITE, 15, 14, 1'b1);
		send_cmd(CMD_WRITE, 14, 15, 1'b1);
		send_cmd(CMD_WRITE, 7, 6, 1'b1);
		send_cmd(CMD_WRITE, 7, 7, 1'b1);
		send_cmd(CMD_WRITE, 7, 8, 1'b1);
		send_cmd(CMD_WRITE, 0, 15, 1'b1);
		// Unused command: no report word may follow.
		send_cmd(CMD_NONE, 5, 9, 1'b1);
		send_cmd(CMD_STEP, 0, 0, 1'b0);
		send_cmd(CMD_STEP, 15, 15, 1'b1);
		send_cmd(CMD_READ, 7, 0, 1'b0);
		send_cmd(CMD_READ, 15, 15, 1'b1);
		// Clear a live cell, then rewrite it.
		send_cmd(CMD_WRITE, 15, 15, 1'b0);
		send_cmd(CMD_WRITE, 15, 15, 1'b1);
		send_cmd(CMD_WRITE, 8, 7, 1'b0);
		send_cmd(CMD_STEP, 0, 0, 1'b0);

		// Pause the sender until the block has emptied.
		wait_empty();

		run_phase(19, 51, 160);
		wait_empty();
		run_phase(51, 19, 160);
		wait_empty();
		run_phase(0, 0, 160);

		// Drain, then wait a while longer so the block can show stray words.
		wait_empty();
		repeat (GRID_ROWS + 4) @(negedge clk);

		if (mismatch_count == 0 && rows_due == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Stop a hung run: far beyond the slowest expected run.
	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
